FILE: hdl/spl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spl_pkg
// Shared widths, codes and structs for the sorted point list.
// ----------------------------------------------------------------------------
package spl_pkg;

  localparam int CAPACITY   = 64;
  localparam int COORD_BITS = 16;
  localparam int ID_BITS    = 16;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int DIST_W     = COORD_BITS + 1;

  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;

  localparam int IN_BITS    = OP_W + 2 * COORD_BITS + ID_BITS;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = STATUS_W + 1 + ID_BITS + 7;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIE_ORDER = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [ID_BITS-1:0]           id;
  } spl_entry_t;

  // values broadcast to every cell
  typedef struct packed {
    spl_entry_t                   pt;      // new point (id = assigned id)
    logic [ID_BITS-1:0]           key;     // lookup key
    logic signed [COORD_BITS-1:0] center;
    logic [DIST_W-1:0]            dn;      // |new x - center|
    logic                         tie_order;
  } spl_bcast_t;

  // per-cell update controls
  typedef struct packed {
    logic load_new;
    logic take_left;
    logic take_right;
  } spl_cell_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/spl_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spl_cell
// One list slot: holds a point, compares it with the broadcast request and
// shifts to or from its neighbors.
// ----------------------------------------------------------------------------
module spl_cell
  import spl_pkg::*;
(
  input  wire logic          clk,
  input  wire spl_bcast_t    bcast,
  input  wire spl_cell_ctl_t ctl,
  input  wire spl_entry_t    left_ent,
  input  wire spl_entry_t    right_ent,
  output spl_entry_t         ent,
  output logic               ahead,    // new point goes in front of this one
  output logic               match     // stored id equals key
);

  logic signed [DIST_W-1:0] diff;
  logic [DIST_W-1:0]        de;

  always_comb begin
    diff = {ent.x[COORD_BITS-1], ent.x} - {bcast.center[COORD_BITS-1], bcast.center};
    de   = diff[DIST_W-1] ? DIST_W'(-diff) : DIST_W'(diff);
    if (bcast.pt.y != ent.y) begin
      ahead = bcast.pt.y < ent.y;
    end else if (bcast.tie_order) begin
      ahead = bcast.dn < de;
    end else begin
      ahead = bcast.dn > de;
    end
    match = ent.id == bcast.key;
  end

  always_ff @(posedge clk) begin
    if (ctl.load_new) begin
      ent <= bcast.pt;
    end else if (ctl.take_left) begin
      ent <= left_ent;
    end else if (ctl.take_right) begin
      ent <= right_ent;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/sorted_point_list_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_point_list_top
// Bounded list of points ordered by y, with insert, remove and search by id.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, cell 0 at the head. Each request
// has an evaluate cycle and an apply cycle: in the evaluate cycle every cell
// compares its point with the request at once (order test and id match), and
// in the apply cycle the row shifts by one place toward the tail (insert) or
// the head (remove) and the result is written to the output register. A new
// request can be taken in the apply cycle of the previous one; the apply cycle
// waits only while the output register holds a result that has not been
// taken. Every request gives exactly one result.
// Configuration writes are always accepted and are meant to land while no
// request is in flight; the center of the anchors is registered in the cycle
// after a write.
// ----------------------------------------------------------------------------
module sorted_point_list_top
  import spl_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // requests: op[1:0], point_x[17:2], point_y[33:18], item_key[49:34]
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  // results: status[1:0], found[2], assigned_id[18:3], count_after[25:19]
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  // configuration writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [COORD_BITS-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EVAL  = 3'b010,
    ST_APPLY = 3'b100
  } state_t;

  state_t state, state_next;

  // configuration
  logic signed [COORD_BITS-1:0] anchor_a, anchor_b, center;
  logic                         tie_order;
  logic signed [COORD_BITS:0]   anchor_sum, anchor_adj;

  // captured request
  logic [OP_W-1:0]              op;
  logic signed [COORD_BITS-1:0] px, py;
  logic [ID_BITS-1:0]           key;

  logic [CNT_W-1:0]             entry_count, count_next;
  logic [CAPACITY-1:0]          live, before_r, match_r;
  logic [CAPACITY-1:0]          before_c, match_c;
  logic [CAPACITY-1:0]          at_or_after;  // slot at or past insert point
  logic [CAPACITY-1:0]          from_hit;     // slot at or past removed entry
  logic [CAPACITY-1:0]          blockers, hits;

  spl_entry_t    ents [CAPACITY];
  spl_cell_ctl_t ctls [CAPACITY];
  spl_bcast_t    bcast;

  logic                  out_free, accept, fire, full, hit_any;
  logic                  do_insert, do_remove;
  logic [ID_BITS-1:0]    assigned;
  logic signed [DIST_W-1:0] dn_diff;
  logic [STATUS_W-1:0]   status;
  logic                  found;
  logic [ID_BITS-1:0]    res_id;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_a  <= '0;
      anchor_b  <= '0;
      tie_order <= 1'b0;
      center    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ANCHOR_A:  anchor_a  <= cfg_data;
          REG_ANCHOR_B:  anchor_b  <= cfg_data;
          REG_TIE_ORDER: tie_order <= cfg_data[0];
          default: ;
        endcase
      end
      center <= anchor_adj[COORD_BITS:1];
    end
  end

  // mean of the anchors, truncated toward zero
  always_comb begin
    anchor_sum = {anchor_a[COORD_BITS-1], anchor_a} + {anchor_b[COORD_BITS-1], anchor_b};
    anchor_adj = anchor_sum + {{COORD_BITS{1'b0}}, anchor_sum[COORD_BITS]};
  end

  // handshake and sequencing
  assign out_free = !m_tvalid || m_tready;
  assign fire     = (state == ST_APPLY) && out_free;
  assign s_tready = (state == ST_IDLE) || fire;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = ST_EVAL;
      ST_EVAL:  state_next = ST_APPLY;
      ST_APPLY: if (fire) state_next = accept ? ST_EVAL : ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= s_tdata[OP_W-1:0];
      px  <= s_tdata[OP_W +: COORD_BITS];
      py  <= s_tdata[OP_W+COORD_BITS +: COORD_BITS];
      key <= s_tdata[OP_W+2*COORD_BITS +: ID_BITS];
    end
    if (state == ST_EVAL) begin
      before_r <= before_c;
      match_r  <= match_c;
    end
  end

  // broadcast to the cells
  always_comb begin
    full     = entry_count >= CNT_W'(CAPACITY);
    assigned = (key == '0) ? ID_BITS'(entry_count + CNT_W'(1)) : key;
    dn_diff  = {px[COORD_BITS-1], px} - {center[COORD_BITS-1], center};
    bcast.pt.x      = px;
    bcast.pt.y      = py;
    bcast.pt.id     = assigned;
    bcast.key       = key;
    bcast.center    = center;
    bcast.dn        = dn_diff[DIST_W-1] ? DIST_W'(-dn_diff) : DIST_W'(dn_diff);
    bcast.tie_order = tie_order;
  end

  // live slots and the suffix / prefix masks that steer the shift
  assign blockers = ~before_r & live;
  assign hits     = match_r & live;
  assign hit_any  = hits != '0;

  assign do_insert = fire && (op == OP_INSERT) && !full;
  assign do_remove = fire && (op == OP_REMOVE) && hit_any;

  genvar k;
  generate
    for (k = 0; k < CAPACITY; k++) begin : g_cell
      assign live[k]        = CNT_W'(k) < entry_count;
      assign at_or_after[k] = (blockers >> k) == '0;
      assign from_hit[k]    = (hits << (CAPACITY - 1 - k)) != '0;

      if (k == 0) begin : g_head
        assign ctls[k].load_new  = do_insert && at_or_after[k];
        assign ctls[k].take_left = 1'b0;
      end else begin : g_body
        assign ctls[k].load_new  = do_insert && at_or_after[k] && !at_or_after[k-1];
        assign ctls[k].take_left = do_insert && at_or_after[k-1];
      end
      assign ctls[k].take_right = do_remove && from_hit[k];

      spl_cell u_cell (
        .clk       (clk),
        .bcast     (bcast),
        .ctl       (ctls[k]),
        .left_ent  ((k == 0) ? spl_entry_t'('0) : ents[(k == 0) ? 0 : k-1]),
        .right_ent ((k == CAPACITY-1) ? spl_entry_t'('0)
                                      : ents[(k == CAPACITY-1) ? k : k+1]),
        .ent       (ents[k]),
        .ahead     (before_c[k]),
        .match     (match_c[k])
      );
    end
  endgenerate

  // result and count
  always_comb begin
    status     = STATUS_DONE;
    found      = 1'b0;
    res_id     = '0;
    count_next = entry_count;
    case (op)
      OP_INSERT: begin
        if (full) begin
          status = STATUS_FULL;
        end else begin
          res_id     = assigned;
          count_next = entry_count + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (hit_any) begin
          found      = 1'b1;
          count_next = entry_count - CNT_W'(1);
        end else begin
          status = STATUS_MISS;
        end
      end
      OP_SEARCH: begin
        if (hit_any) begin
          found = 1'b1;
        end else begin
          status = STATUS_MISS;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (fire) begin
        entry_count <= count_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= OUT_TDATA_W'({7'(count_next), res_id, found, status});
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    do_insert |=> entry_count == $past(entry_count) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[STATUS_W-1:0] == STATUS_FULL |-> entry_count == CNT_W'(CAPACITY))
    else $error("full status with room left");

  a_found_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[STATUS_W] |-> m_tdata[STATUS_W-1:0] == STATUS_DONE)
    else $error("found flag with a failing status");

  a_one_shift: assert property (@(posedge clk) disable iff (rst)
    !(do_insert && do_remove) && (fire || (!do_insert && !do_remove)))
    else $error("conflicting shift directions");

endmodule
`default_nettype wire
